// ===== hw/rtl/wso_pkg.sv =====
// wheel speed odometer package: field widths, reset values, register indexes,
// sequencer codes and the request/response structs of the serial divider
// no dependencies
package wso_pkg;

    localparam int PUL_W  = 4;
    localparam int CIRC_W = 22;
    localparam int PPR_W  = 11;
    localparam int WIN_W  = 10;
    localparam int STALE_W = 16;
    localparam int MINS_W = 20;

    localparam int MM_W   = 32;
    localparam int MH_W   = 40;
    localparam int TOT_W  = 48;
    localparam int CNT_W  = 16;

    localparam int PROD_W = CIRC_W + CNT_W;   // pulses times circumference
    localparam int DIV_W  = 56;               // serial divider dividend width
    localparam int DVS_W  = 14;               // divisor up to window*10
    localparam int STEP_W = 6;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_CIRC  = 3'd0;
    localparam logic [2:0] REG_PPR   = 3'd1;
    localparam logic [2:0] REG_WIN   = 3'd2;
    localparam logic [2:0] REG_STALE = 3'd3;
    localparam logic [2:0] REG_MINS  = 3'd4;

    localparam logic [CIRC_W-1:0]  CIRC_RST  = 22'd200000;
    localparam logic [PPR_W-1:0]   PPR_RST   = 11'd20;
    localparam logic [WIN_W-1:0]   WIN_RST   = 10'd10;
    localparam logic [STALE_W-1:0] STALE_RST = 16'd500;
    localparam logic [MINS_W-1:0]  MINS_RST  = 20'd500;

    localparam logic [DVS_W-1:0] DVS_TEN = 14'd10;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        OP_DIST,
        OP_MM,
        OP_SMM,
        OP_MH,
        OP_SMH
    } op_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;   // left aligned: top steps bits are used
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/wso_tick_if.sv =====
// tick channel: valid/ready handshake carrying the pulse count of one millisecond
// depends on wso_pkg
interface wso_tick_if import wso_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PUL_W-1:0] pulses;

    modport source (output valid, output pulses, input ready);
    modport sink (input valid, input pulses, output ready);
endinterface

// ===== hw/rtl/wso_result_if.sv =====
// result channel: valid/ready handshake carrying speeds, distance and counters
// depends on wso_pkg
interface wso_result_if import wso_pkg::*;;
    logic               valid;
    logic               ready;
    logic [MM_W-1:0]    speed_mm_s_q8;
    logic [MH_W-1:0]    speed_m_per_h_q8;
    logic [TOT_W-1:0]   total_distance_um;
    logic [CNT_W-1:0]   pending_pulses;
    logic [CNT_W-1:0]   idle_ms;
    logic               updated;

    modport source (output valid, output speed_mm_s_q8, output speed_m_per_h_q8,
                    output total_distance_um, output pending_pulses, output idle_ms,
                    output updated, input ready);
    modport sink (input valid, input speed_mm_s_q8, input speed_m_per_h_q8,
                  input total_distance_um, input pending_pulses, input idle_ms,
                  input updated, output ready);
endinterface

// ===== hw/rtl/wheel_speed_odometer.sv =====
// wheel speed odometer top level: tick counting, window sequencer, apb registers
// depends on wso_pkg, wso_tick_if, wso_result_if and wso_div
//
// One request on the tick channel is one millisecond with the number of sensor
// edges seen in it; every tick gives exactly one result. A tick that does not
// close the measurement window is answered in the cycle after it is taken. A tick
// that closes the window runs the window arithmetic on bit-serial hardware: a
// 16-step shift-and-add multiply of the pulse count by the circumference, then
// five passes through one shared restoring divider at one bit per cycle
// (distance 38 bits, mm/s 46, smoothed mm/s 56, m/h 52, smoothed m/h 56),
// so the result of such a tick appears only after the last pass. The block
// takes one tick at a time and takes a new one only when the last result has
// gone or goes in the same cycle. Registers are written and read over the apb
// port at byte address 4*index; writes belong to idle periods only.
module wheel_speed_odometer import wso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    wso_tick_if.sink           tick,
    wso_result_if.source       result
);

    // configuration registers
    logic [CIRC_W-1:0]  circ_reg;
    logic [PPR_W-1:0]   ppr_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [STALE_W-1:0] stale_reg;
    logic [MINS_W-1:0]  mins_reg;

    // tick and window state
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [WIN_W-1:0]   msw_reg, msw_next;
    logic [CNT_W-1:0]   wpc_reg, wpc_next;
    logic [CNT_W-1:0]   idle_reg, idle_next;
    logic               seen_reg, seen_next;
    logic [MM_W-1:0]    smm_reg, smm_next;
    logic [MH_W-1:0]    smh_reg, smh_next;
    logic [TOT_W-1:0]   tot_reg, tot_next;
    logic               out_valid_reg, out_valid_next;
    logic               updated_reg, updated_next;

    // serial datapath
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [3:0]         mul_cnt_reg, mul_cnt_next;
    logic [PROD_W-1:0]  dist_reg, dist_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    wso_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // apb
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_CIRC:  prdata = {{(DATA_W-CIRC_W){1'b0}}, circ_reg};
            REG_PPR:   prdata = {{(DATA_W-PPR_W){1'b0}}, ppr_reg};
            REG_WIN:   prdata = {{(DATA_W-WIN_W){1'b0}}, win_reg};
            REG_STALE: prdata = {{(DATA_W-STALE_W){1'b0}}, stale_reg};
            REG_MINS:  prdata = {{(DATA_W-MINS_W){1'b0}}, mins_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg  <= CIRC_RST;
            ppr_reg   <= PPR_RST;
            win_reg   <= WIN_RST;
            stale_reg <= STALE_RST;
            mins_reg  <= MINS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CIRC:  circ_reg  <= pwdata[CIRC_W-1:0];
                REG_PPR:   ppr_reg   <= pwdata[PPR_W-1:0];
                REG_WIN:   win_reg   <= pwdata[WIN_W-1:0];
                REG_STALE: stale_reg <= pwdata[STALE_W-1:0];
                REG_MINS:  mins_reg  <= pwdata[MINS_W-1:0];
                default:   ;
            endcase
        end
    end

    // zero window and zero pulses per rev behave as one
    logic [WIN_W-1:0] win_eff;
    logic [PPR_W-1:0] ppr_eff;
    logic [DVS_W-1:0] win_dvs;
    logic [DVS_W-1:0] win10_dvs;

    assign win_eff   = (win_reg == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : win_reg;
    assign ppr_eff   = (ppr_reg == '0) ? {{(PPR_W-1){1'b0}}, 1'b1} : ppr_reg;
    assign win_dvs   = {{(DVS_W-WIN_W){1'b0}}, win_eff};
    assign win10_dvs = (win_dvs << 3) + (win_dvs << 1);

    // handshake
    logic taken;
    logic accept;

    assign taken        = out_valid_reg && result.ready;
    assign tick.ready   = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept       = tick.valid && tick.ready;

    // tick bookkeeping
    logic [CNT_W:0]     wpc_sum;
    logic [CNT_W-1:0]   wpc_sat;
    logic [WIN_W-1:0]   msw_inc;
    logic               close;

    assign wpc_sum = {1'b0, wpc_reg} + {{(CNT_W+1-PUL_W){1'b0}}, tick.pulses};
    assign wpc_sat = wpc_sum[CNT_W] ? '1 : wpc_sum[CNT_W-1:0];
    assign msw_inc = msw_reg + 1'b1;
    // a shrunk window closes at once, a wrapped count closes too
    assign close   = (msw_inc >= win_eff) || (msw_inc == '0);

    // bit-serial multiply step: low half shifts the pulse count out
    logic [CIRC_W:0] mul_sum;
    logic [PROD_W-1:0] acc_step;

    assign mul_sum  = {1'b0, acc_reg[PROD_W-1:CNT_W]}
                    + (acc_reg[0] ? {1'b0, circ_reg} : '0);
    assign acc_step = {mul_sum, acc_reg[CNT_W-1:1]};

    // dividends, left aligned to the divider width
    logic [DIV_W-1:0] dist_x;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] smm_x;
    logic [DIV_W-1:0] smh_x;
    logic [DIV_W-1:0] sum_mm;
    logic [DIV_W-1:0] sum_mh;
    logic [DIV_W-1:0] mh_num;
    logic [MH_W-1:0]  mh_thr;
    logic [TOT_W:0]   tot_sum;
    logic [MM_W-1:0]  smm_sat;
    logic [MH_W-1:0]  smh_sat;

    assign quo    = div_rsp.quotient;
    assign dist_x = {{(DIV_W-PROD_W){1'b0}}, dist_reg};
    assign smm_x  = {{(DIV_W-MM_W){1'b0}}, smm_reg};
    assign smh_x  = {{(DIV_W-MH_W){1'b0}}, smh_reg};
    // 7*old + 3*new, the divide by ten follows in the divider
    assign sum_mm = (smm_x << 3) - smm_x
                  + ({10'b0, quo[45:0]} << 1) + {10'b0, quo[45:0]};
    assign sum_mh = (smh_x << 3) - smh_x
                  + ({4'b0, quo[51:0]} << 1) + {4'b0, quo[51:0]};
    // distance * 256 * 36, below 2^52
    assign mh_num = (dist_x << 13) + (dist_x << 10);

    assign smm_sat = (quo[DIV_W-1:MM_W] != '0) ? '1 : quo[MM_W-1:0];
    assign smh_sat = (quo[DIV_W-1:MH_W] != '0) ? '1 : quo[MH_W-1:0];
    assign mh_thr  = {{(MH_W-MINS_W-8){1'b0}}, mins_reg, 8'b0};
    assign tot_sum = {1'b0, tot_reg} + {{(TOT_W+1-PROD_W){1'b0}}, dist_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        msw_next       = msw_reg;
        wpc_next       = wpc_reg;
        idle_next      = idle_reg;
        seen_next      = seen_reg;
        smm_next       = smm_reg;
        smh_next       = smh_reg;
        tot_next       = tot_reg;
        out_valid_next = taken ? 1'b0 : out_valid_reg;
        updated_next   = updated_reg;
        acc_next       = acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        dist_next      = dist_reg;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DVS_TEN;
        div_req.steps    = STEP_W'(DIV_W);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (tick.pulses != '0)
                    begin
                        idle_next = '0;
                        seen_next = 1'b1;
                    end
                    else if (idle_reg != '1)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end

                    if (close)
                    begin
                        msw_next     = '0;
                        wpc_next     = '0;
                        acc_next     = {{CIRC_W{1'b0}}, wpc_sat};
                        mul_cnt_next = '0;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        msw_next       = msw_inc;
                        wpc_next       = wpc_sat;
                        updated_next   = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end

            S_MUL:
            begin
                acc_next     = acc_step;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == '1)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {acc_step, {(DIV_W-PROD_W){1'b0}}};
                    div_req.divisor  = {{(DVS_W-PPR_W){1'b0}}, ppr_eff};
                    div_req.steps    = STEP_W'(PROD_W);
                    op_next          = OP_DIST;
                    state_next       = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (op_reg)
                        OP_DIST:
                        begin
                            dist_next        = quo[PROD_W-1:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = {quo[PROD_W-1:0], 8'b0,
                                                {(DIV_W-PROD_W-8){1'b0}}};
                            div_req.divisor  = win_dvs;
                            div_req.steps    = STEP_W'(PROD_W + 8);
                            op_next          = OP_MM;
                        end
                        OP_MM:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = sum_mm;
                            div_req.divisor  = DVS_TEN;
                            div_req.steps    = STEP_W'(DIV_W);
                            op_next          = OP_SMM;
                        end
                        OP_SMM:
                        begin
                            smm_next         = smm_sat;
                            div_req.start    = 1'b1;
                            div_req.dividend = {mh_num[51:0], 4'b0};
                            div_req.divisor  = win10_dvs;
                            div_req.steps    = STEP_W'(52);
                            op_next          = OP_MH;
                        end
                        OP_MH:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = sum_mh;
                            div_req.divisor  = DVS_TEN;
                            div_req.steps    = STEP_W'(DIV_W);
                            op_next          = OP_SMH;
                        end
                        OP_SMH:
                        begin
                            smh_next   = smh_sat;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                // distance counts on the smoothed value before the stale check
                if (smh_reg >= mh_thr)
                begin
                    tot_next = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                end
                if (seen_reg && (idle_reg > stale_reg))
                begin
                    smm_next = '0;
                    smh_next = '0;
                end
                updated_next   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_DIST;
            msw_reg       <= '0;
            wpc_reg       <= '0;
            idle_reg      <= '0;
            seen_reg      <= 1'b0;
            smm_reg       <= '0;
            smh_reg       <= '0;
            tot_reg       <= '0;
            out_valid_reg <= 1'b0;
            updated_reg   <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            msw_reg       <= msw_next;
            wpc_reg       <= wpc_next;
            idle_reg      <= idle_next;
            seen_reg      <= seen_next;
            smm_reg       <= smm_next;
            smh_reg       <= smh_next;
            tot_reg       <= tot_next;
            out_valid_reg <= out_valid_next;
            updated_reg   <= updated_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        dist_reg <= dist_next;
    end

    // the result shows the state itself: it only changes once the result is gone
    assign result.valid             = out_valid_reg;
    assign result.speed_mm_s_q8     = smm_reg;
    assign result.speed_m_per_h_q8  = smh_reg;
    assign result.total_distance_um = tot_reg;
    assign result.pending_pulses    = wpc_reg;
    assign result.idle_ms           = idle_reg;
    assign result.updated           = updated_reg;

`ifndef SYNTHESIS
    // the divider only answers while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    // a taken tick yields a result next cycle or starts the window arithmetic
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (result.valid || (state_reg == S_MUL)))
        else $error("tick taken without result or window arithmetic");

    // a closing result always leaves an empty pending window
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.updated) |-> (result.pending_pulses == '0))
        else $error("window closed with pulses still pending");

    // no result is raised while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) || (state_reg == S_DIV)) |-> !result.valid)
        else $error("result valid during window arithmetic");
`endif

endmodule

// ===== hw/rtl/wso_div.sv =====
// restoring divider, one quotient bit per cycle, dividend given left aligned
// depends on wso_pkg
module wso_div import wso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = req.steps - 1'b1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
